[design/srgp_pkg.sv]
package srgp_pkg;

  // Move count and chain depth limits (four-bit count field in the length byte)
  localparam int CNT_W         = 4;
  localparam int MAX_MOVES_DEF = 15;
  localparam int KEY_W         = 40;
  localparam int MOVE_W        = 16;
  localparam int BYTE_W        = 8;
  localparam int STAT_W        = 16;
  localparam int HDR_LAST      = 4;   // index of the length byte in the header

  localparam logic [STAT_W-1:0] STAT_MAX = '1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROC,
    ST_HDR,
    ST_FROM,
    ST_TO
  } state_t;

  // Per-cycle command broadcast to every cell of the move chain
  typedef struct packed {
    logic shift;   // every cell takes its right neighbor's contents
    logic insert;  // first empty cell captures the new move
  } cell_ctrl_t;

endpackage

[design/sorted_record_group_packer_top.sv]
// Sorted record group packer.
// Input channel (in_valid/in_ready): one transaction per record. action 0 adds
// a record {position_key, from_square, to_square}; action 1 ends the list and
// flushes the open group. Output channel (out_valid/out_ready): one transaction
// per byte of a packed group line, last_of_line on its final byte, with the
// running statistics (groups_done, distinct_moves, most_moves, dropped_moves)
// as they stood at the flush.
// Flow: an add record that does not close a group is accepted, then gets one
// compare/insert step in the move chain. A record that closes a group with n
// moves first sends a line of 5 + 2n bytes while the group drains out of the
// chain, one byte per cycle while out_ready holds, then, if it adds a move,
// gets its own insert step. Input is taken only while the block is idle.
// The move chain is one cell per stored move: dedup compares run in all cells
// in parallel, and the drain shifts the chain toward its head.
// Reset (rst, synchronous): no open group, chain empty, statistics zero.
// Receiver stall: the output register holds its byte and fields; draining
// pauses until out_ready, and no new record is taken meanwhile.
module sorted_record_group_packer_top #(
  parameter int MAX_MOVES = srgp_pkg::MAX_MOVES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               action,
  input  logic [srgp_pkg::KEY_W-1:0]         position_key,
  input  logic [srgp_pkg::BYTE_W-1:0]        from_square,
  input  logic [srgp_pkg::BYTE_W-1:0]        to_square,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [srgp_pkg::BYTE_W-1:0]        out_byte,
  output logic                               last_of_line,
  output logic [srgp_pkg::STAT_W-1:0]        groups_done,
  output logic [srgp_pkg::STAT_W-1:0]        distinct_moves,
  output logic [srgp_pkg::CNT_W-1:0]         most_moves,
  output logic [srgp_pkg::STAT_W-1:0]        dropped_moves
);

  localparam logic [srgp_pkg::CNT_W-1:0] CAP = srgp_pkg::CNT_W'(MAX_MOVES);

  srgp_pkg::state_t state, state_next;

  // Captured record
  logic                          act_r;
  logic [srgp_pkg::KEY_W-1:0]    key_r;
  logic [srgp_pkg::MOVE_W-1:0]   move_r;

  // Group state
  logic                          group_open;
  logic [srgp_pkg::KEY_W-1:0]    group_key;
  logic [srgp_pkg::CNT_W-1:0]    move_count;
  logic                          pend_add;   // record waiting behind a flush
  logic [2:0]                    hdr_idx;
  logic                          first_pair;

  // Statistics
  logic [srgp_pkg::STAT_W-1:0]   grp_cnt;
  logic [srgp_pkg::STAT_W-1:0]   mv_cnt;
  logic [srgp_pkg::CNT_W-1:0]    max_seen;
  logic [srgp_pkg::STAT_W-1:0]   drop_cnt;

  // Chain interface
  srgp_pkg::cell_ctrl_t          ctrl;
  logic                          any_match;
  logic                          head_occ;
  logic [srgp_pkg::MOVE_W-1:0]   head_move;

  logic                          accept;
  logic                          flush;
  logic                          do_add;
  logic                          ins;
  logic                          drop;
  logic                          ob_load;
  logic                          emit_done;
  logic [srgp_pkg::BYTE_W-1:0]   byte_next;
  logic                          last_next;
  logic [srgp_pkg::CNT_W-1:0]    count_inc;

  assign accept    = in_valid && in_ready;
  assign flush     = act_r ? group_open : (group_open && (key_r != group_key));
  assign do_add    = !act_r && !flush;
  assign ins       = do_add && !any_match && (move_count < CAP);
  assign drop      = do_add && !any_match && !(move_count < CAP);
  assign count_inc = move_count + 1'b1;

  // Byte producer: loads the output register when it is empty or being taken
  assign ob_load = ((state == srgp_pkg::ST_HDR) || (state == srgp_pkg::ST_FROM) ||
                    (state == srgp_pkg::ST_TO)) && (!out_valid || out_ready);

  assign emit_done = ob_load &&
                     (((state == srgp_pkg::ST_HDR) && (hdr_idx == 3'(srgp_pkg::HDR_LAST)) &&
                       (move_count == '0)) ||
                      ((state == srgp_pkg::ST_TO) && (move_count == 4'd1)));

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      srgp_pkg::ST_IDLE: begin
        if (accept) state_next = srgp_pkg::ST_PROC;
      end
      srgp_pkg::ST_PROC: begin
        state_next = flush ? srgp_pkg::ST_HDR : srgp_pkg::ST_IDLE;
      end
      srgp_pkg::ST_HDR: begin
        if (emit_done) begin
          state_next = pend_add ? srgp_pkg::ST_PROC : srgp_pkg::ST_IDLE;
        end else if (ob_load && (hdr_idx == 3'(srgp_pkg::HDR_LAST))) begin
          state_next = srgp_pkg::ST_FROM;
        end
      end
      srgp_pkg::ST_FROM: begin
        if (ob_load) state_next = srgp_pkg::ST_TO;
      end
      srgp_pkg::ST_TO: begin
        if (emit_done) begin
          state_next = pend_add ? srgp_pkg::ST_PROC : srgp_pkg::ST_IDLE;
        end else if (ob_load) begin
          state_next = srgp_pkg::ST_FROM;
        end
      end
      default: state_next = srgp_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_ready    = 1'b0;
    ctrl.shift  = 1'b0;
    ctrl.insert = 1'b0;
    byte_next   = '0;
    last_next   = 1'b0;
    case (state)
      srgp_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      srgp_pkg::ST_PROC: begin
        ctrl.insert = ins;
      end
      srgp_pkg::ST_HDR: begin
        case (hdr_idx)
          3'd0:    byte_next = group_key[39:32];
          3'd1:    byte_next = group_key[31:24];
          3'd2:    byte_next = group_key[23:16];
          3'd3:    byte_next = group_key[15:8];
          default: byte_next = {group_key[7:4], move_count};
        endcase
        last_next = (hdr_idx == 3'(srgp_pkg::HDR_LAST)) && (move_count == '0);
      end
      srgp_pkg::ST_FROM: begin
        byte_next = head_move[15:8] |
                    (first_pair ? {group_key[3:2], 6'b0} : 8'h00);
      end
      srgp_pkg::ST_TO: begin
        byte_next  = head_move[7:0] |
                     (first_pair ? {group_key[1:0], 6'b0} : 8'h00);
        last_next  = (move_count == 4'd1);
        ctrl.shift = ob_load;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= srgp_pkg::ST_IDLE;
      group_open <= 1'b0;
      move_count <= '0;
      pend_add   <= 1'b0;
      hdr_idx    <= '0;
      first_pair <= 1'b0;
      grp_cnt    <= '0;
      mv_cnt     <= '0;
      max_seen   <= '0;
      drop_cnt   <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;

      if (state == srgp_pkg::ST_PROC) begin
        if (flush) begin
          pend_add   <= !act_r;
          hdr_idx    <= '0;
          first_pair <= 1'b1;
          if (grp_cnt != srgp_pkg::STAT_MAX) grp_cnt <= grp_cnt + 1'b1;
        end else if (do_add) begin
          group_open <= 1'b1;
          if (ins) begin
            move_count <= count_inc;
            if (mv_cnt != srgp_pkg::STAT_MAX) mv_cnt <= mv_cnt + 1'b1;
            if (count_inc > max_seen) max_seen <= count_inc;
          end
          if (drop && (drop_cnt != srgp_pkg::STAT_MAX)) drop_cnt <= drop_cnt + 1'b1;
        end
      end

      if (ob_load) begin
        if (state == srgp_pkg::ST_HDR) hdr_idx <= hdr_idx + 1'b1;
        if (state == srgp_pkg::ST_TO) begin
          move_count <= move_count - 1'b1;
          first_pair <= 1'b0;
        end
      end
      if (emit_done) group_open <= 1'b0;

      if (ob_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      act_r  <= action;
      key_r  <= position_key;
      move_r <= {from_square, to_square};
    end
    if ((state == srgp_pkg::ST_PROC) && do_add) group_key <= key_r;
    if (ob_load) begin
      out_byte       <= byte_next;
      last_of_line   <= last_next;
      groups_done    <= grp_cnt;
      distinct_moves <= mv_cnt;
      most_moves     <= max_seen;
      dropped_moves  <= drop_cnt;
    end
  end

  srgp_chain #(
    .MAX_MOVES (MAX_MOVES)
  ) u_chain (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .new_move  (move_r),
    .any_match (any_match),
    .head_occ  (head_occ),
    .head_move (head_move)
  );

`ifndef ASSERT_OFF
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    move_count <= CAP)
    else $error("move count above capacity");

  a_closed_empty: assert property (@(posedge clk) disable iff (rst)
    !group_open |-> (move_count == '0) && !head_occ)
    else $error("closed group leaves moves in the chain");

  a_flush_starts: assert property (@(posedge clk) disable iff (rst)
    (state == srgp_pkg::ST_PROC) && flush |=> (state == srgp_pkg::ST_HDR))
    else $error("flush did not start header emission");

  a_last_pair: assert property (@(posedge clk) disable iff (rst)
    ob_load && (state == srgp_pkg::ST_TO) && (move_count == 4'd1) |=>
    out_valid && last_of_line)
    else $error("final pair not flagged as end of line");

  a_drain_head: assert property (@(posedge clk) disable iff (rst)
    (state == srgp_pkg::ST_FROM) || (state == srgp_pkg::ST_TO) |-> head_occ)
    else $error("pair emission from an empty chain head");
`endif

endmodule

[design/srgp_cell.sv]
module srgp_cell (
  input  logic                              clk,
  input  logic                              rst,
  input  srgp_pkg::cell_ctrl_t              ctrl,
  input  logic [srgp_pkg::MOVE_W-1:0]       new_move,
  input  logic                              left_occ,
  input  logic                              right_occ,
  input  logic [srgp_pkg::MOVE_W-1:0]       right_move,
  output logic                              occ,
  output logic [srgp_pkg::MOVE_W-1:0]       move,
  output logic                              match
);

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else if (ctrl.shift) begin
      occ <= right_occ;
    end else if (ctrl.insert && !occ && left_occ) begin
      occ <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      move <= right_move;
    end else if (ctrl.insert && !occ && left_occ) begin
      move <= new_move;
    end
  end

  assign match = occ && (move == new_move);

endmodule

[design/srgp_chain.sv]
module srgp_chain #(
  parameter int MAX_MOVES = srgp_pkg::MAX_MOVES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  srgp_pkg::cell_ctrl_t              ctrl,
  input  logic [srgp_pkg::MOVE_W-1:0]       new_move,
  output logic                              any_match,
  output logic                              head_occ,
  output logic [srgp_pkg::MOVE_W-1:0]       head_move
);

  logic [MAX_MOVES-1:0]      occ;
  logic [MAX_MOVES-1:0]      match;
  logic [srgp_pkg::MOVE_W-1:0] move [MAX_MOVES];

  for (genvar i = 0; i < MAX_MOVES; i++) begin : g_cell
    logic                        left_occ;
    logic                        right_occ;
    logic [srgp_pkg::MOVE_W-1:0] right_move;

    if (i == 0) begin : g_head
      assign left_occ = 1'b1;
    end else begin : g_body
      assign left_occ = occ[i-1];
    end

    if (i == MAX_MOVES - 1) begin : g_tail
      assign right_occ  = 1'b0;
      assign right_move = '0;
    end else begin : g_inner
      assign right_occ  = occ[i+1];
      assign right_move = move[i+1];
    end

    srgp_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .new_move   (new_move),
      .left_occ   (left_occ),
      .right_occ  (right_occ),
      .right_move (right_move),
      .occ        (occ[i]),
      .move       (move[i]),
      .match      (match[i])
    );
  end

  assign any_match = |match;
  assign head_occ  = occ[0];
  assign head_move = move[0];

endmodule

[verif/sorted_record_group_packer_top_tb.sv]
`timescale 1ns / 100ps

module sorted_record_group_packer_top_tb;

  localparam int KEY_W  = srgp_pkg::KEY_W;
  localparam int BYTE_W = srgp_pkg::BYTE_W;
  localparam int MOVE_W = srgp_pkg::MOVE_W;
  localparam int STAT_W = srgp_pkg::STAT_W;
  localparam int CNT_W  = srgp_pkg::CNT_W;
  localparam logic [STAT_W-1:0] STAT_MAX = srgp_pkg::STAT_MAX;

  // Record opcodes on the action port
  localparam logic ACT_ADD = 1'b0;
  localparam logic ACT_END = 1'b1;

  localparam int GROUP_CAP  = srgp_pkg::MAX_MOVES_DEF;
  localparam int RAND_ITEMS = 280;
  localparam int DRAIN_CYC  = 40;   // settle time after the last byte line

  // One input transaction plus the idle cycles the driver waits after it
  typedef struct {
    logic                act;
    logic [KEY_W-1:0]    key;
    logic [BYTE_W-1:0]   from_sq;
    logic [BYTE_W-1:0]   to_sq;
    int unsigned         gap;
  } record_t;

  // One expected byte of a packed line, with the statistics at the flush
  typedef struct {
    logic [BYTE_W-1:0]   value;
    logic                last;
    logic [STAT_W-1:0]   groups;
    logic [STAT_W-1:0]   moves;
    logic [CNT_W-1:0]    most;
    logic [STAT_W-1:0]   dropped;
  } line_byte_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                action = ACT_ADD;
  logic [KEY_W-1:0]    position_key = '0;
  logic [BYTE_W-1:0]   from_square = '0;
  logic [BYTE_W-1:0]   to_square = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [BYTE_W-1:0]   out_byte;
  logic                last_of_line;
  logic [STAT_W-1:0]   groups_done;
  logic [STAT_W-1:0]   distinct_moves;
  logic [CNT_W-1:0]    most_moves;
  logic [STAT_W-1:0]   dropped_moves;

  sorted_record_group_packer_top #(.MAX_MOVES(GROUP_CAP)) dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .action         (action),
    .position_key   (position_key),
    .from_square    (from_square),
    .to_square      (to_square),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .last_of_line   (last_of_line),
    .groups_done    (groups_done),
    .distinct_moves (distinct_moves),
    .most_moves     (most_moves),
    .dropped_moves  (dropped_moves)
  );

  always #5 clk = ~clk;

  record_t     record_q[$];      // records waiting for the driver
  line_byte_t  line_bytes_q[$];  // bytes predicted but not yet seen
  int          errors = 0;
  int unsigned rx_count = 0;

  // Predictor state: open group, its move list and the running statistics
  logic [KEY_W-1:0]   grp_key = '0;
  logic               grp_open = 1'b0;
  int unsigned        grp_moves = 0;
  logic [MOVE_W-1:0]  grp_store[GROUP_CAP];
  logic [STAT_W-1:0]  stat_groups = '0;
  logic [STAT_W-1:0]  stat_moves = '0;
  logic [CNT_W-1:0]   stat_most = '0;
  logic [STAT_W-1:0]  stat_dropped = '0;

  function automatic void push_line_byte(logic [BYTE_W-1:0] b, logic last);
    line_byte_t e;
    e.value   = b;
    e.last    = last;
    e.groups  = stat_groups;
    e.moves   = stat_moves;
    e.most    = stat_most;
    e.dropped = stat_dropped;
    line_bytes_q.push_back(e);
  endfunction

  // Emit the open group as a byte line: 4 key bytes, length byte, move pairs
  function automatic void flush_group();
    logic [7:0] low;
    logic [7:0] f;
    logic [7:0] t;
    low = grp_key[7:0];
    if (stat_groups != STAT_MAX) stat_groups = stat_groups + 1'b1;
    push_line_byte(grp_key[39:32], 1'b0);
    push_line_byte(grp_key[31:24], 1'b0);
    push_line_byte(grp_key[23:16], 1'b0);
    push_line_byte(grp_key[15:8], 1'b0);
    push_line_byte({low[7:4], 4'(grp_moves)}, grp_moves == 0);
    for (int i = 0; i < grp_moves; i++) begin
      f = grp_store[i][15:8];
      t = grp_store[i][7:0];
      // low key bits ride in the top of the first pair
      if (i == 0) begin
        f[7:6] = f[7:6] | low[3:2];
        t[7:6] = t[7:6] | low[1:0];
      end
      push_line_byte(f, 1'b0);
      push_line_byte(t, i + 1 == grp_moves);
    end
  endfunction

  function automatic void add_group_move(logic [MOVE_W-1:0] mv);
    for (int i = 0; i < grp_moves; i++)
      if (grp_store[i] == mv) return;
    if (grp_moves < GROUP_CAP) begin
      grp_store[grp_moves] = mv;
      grp_moves++;
      if (stat_moves != STAT_MAX) stat_moves = stat_moves + 1'b1;
      if (grp_moves > stat_most) stat_most = CNT_W'(grp_moves);
    end else if (stat_dropped != STAT_MAX) begin
      stat_dropped = stat_dropped + 1'b1;
    end
  endfunction

  function automatic void pack_record(logic act, logic [KEY_W-1:0] key,
                                      logic [BYTE_W-1:0] fs, logic [BYTE_W-1:0] ts);
    if (act == ACT_END) begin
      if (grp_open) flush_group();
      grp_open  = 1'b0;
      grp_moves = 0;
      return;
    end
    if (grp_open && key != grp_key) begin
      flush_group();
      grp_open = 1'b0;
    end
    if (!grp_open) begin
      grp_open  = 1'b1;
      grp_key   = key;
      grp_moves = 0;
    end
    add_group_move({fs, ts});
  endfunction

  task automatic check_field(string name, logic [STAT_W-1:0] exp_v,
                             logic [STAT_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      errors++;
    end
  endtask

  // Handshake flags seen at the last rising edge, used by the negedge drivers
  logic in_taken = 1'b0;
  logic out_taken = 1'b0;

  // Monitor: sample both channels at the rising edge; check bytes, then
  // predict from any record accepted on the same edge.
  always @(posedge clk) begin
    line_byte_t e;
    if (rst) begin
      in_taken  <= 1'b0;
      out_taken <= 1'b0;
    end else begin
      in_taken  <= in_valid && in_ready;
      out_taken <= out_valid && out_ready;
      if (out_valid && out_ready) begin
        rx_count++;
        if (line_bytes_q.size() == 0) begin
          $error("out transaction with no byte pending: out_byte %0h", out_byte);
          errors++;
        end else begin
          e = line_bytes_q.pop_front();
          check_field("out_byte", STAT_W'(e.value), STAT_W'(out_byte));
          check_field("last_of_line", STAT_W'(e.last), STAT_W'(last_of_line));
          check_field("groups_done", e.groups, groups_done);
          check_field("distinct_moves", e.moves, distinct_moves);
          check_field("most_moves", STAT_W'(e.most), STAT_W'(most_moves));
          check_field("dropped_moves", e.dropped, dropped_moves);
        end
      end
      if (in_valid && in_ready)
        pack_record(action, position_key, from_square, to_square);
    end
  end

  // Driver: holds a record until taken, then idles for its drawn gap
  record_t     cur_rec;
  int unsigned gap_left = 0;

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else if (in_valid && !in_taken) begin
      // stalled: keep valid and payload steady
    end else if (gap_left > 0) begin
      in_valid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (record_q.size() > 0) begin
      cur_rec = record_q.pop_front();
      action       <= cur_rec.act;
      position_key <= cur_rec.key;
      from_square  <= cur_rec.from_sq;
      to_square    <= cur_rec.to_sq;
      in_valid     <= 1'b1;
      gap_left     <= cur_rec.gap;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver: after each byte, stall for a random draw, possibly none; every
  // fourth stretch of 64 bytes runs with no stalls.
  int unsigned stall_left = 0;
  int unsigned stall_draw;

  always @(negedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (out_taken) begin
      stall_draw = (((rx_count >> 6) % 4) == 3) ? 0 : $urandom_range(0, 10);
      if (stall_draw == 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready  <= 1'b0;
        stall_left <= stall_draw - 1;
      end
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Queue one record; every third stretch of 40 records has no input gaps
  task automatic queue_record(logic act, logic [KEY_W-1:0] key,
                              logic [BYTE_W-1:0] fs, logic [BYTE_W-1:0] ts);
    record_t r;
    r.act     = act;
    r.key     = key;
    r.from_sq = fs;
    r.to_sq   = ts;
    r.gap     = (((record_q.size() / 40) % 3) == 2) ? 0 : $urandom_range(0, 10);
    record_q.push_back(r);
  endtask

  function automatic logic [KEY_W-1:0] rand_key();
    logic [7:0]  hi;
    logic [31:0] lo;
    hi = 8'($urandom_range(0, 255));
    lo = $urandom;
    return {hi, lo};
  endfunction

  // Random group stream: mostly well-formed groups, some end items as noise
  task automatic queue_random_stream(int unsigned n_items);
    logic [KEY_W-1:0]  key;
    logic [KEY_W-1:0]  prev_key;
    logic [BYTE_W-1:0] fs;
    logic [BYTE_W-1:0] ts;
    int unsigned       roll;
    int unsigned       grp_len;
    bit                narrow;
    int unsigned       target;
    target   = record_q.size() + n_items;
    prev_key = rand_key();
    while (record_q.size() < target) begin
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        // end of list, sometimes doubled; key and move are junk
        queue_record(ACT_END, rand_key(), BYTE_W'($urandom_range(0, 255)),
                     BYTE_W'($urandom_range(0, 255)));
        if (roll < 2)
          queue_record(ACT_END, rand_key(), BYTE_W'($urandom_range(0, 255)),
                       BYTE_W'($urandom_range(0, 255)));
      end else begin
        if (roll < 18)      key = prev_key;
        else if (roll < 35) key = prev_key ^ KEY_W'($urandom_range(1, 255));
        else                key = rand_key();
        prev_key = key;
        grp_len = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 20) : $urandom_range(1, 6);
        narrow  = 1'($urandom_range(0, 1));
        for (int j = 0; j < grp_len; j++) begin
          // narrow pool forces duplicate moves and full groups
          fs = narrow ? BYTE_W'($urandom_range(0, 3)) : BYTE_W'($urandom_range(0, 255));
          ts = narrow ? BYTE_W'($urandom_range(0, 3)) : BYTE_W'($urandom_range(0, 255));
          queue_record(ACT_ADD, key, fs, ts);
        end
      end
    end
    queue_record(ACT_END, '0, '0, '0);
  endtask

  initial begin
    logic [KEY_W-1:0] mid_key;
    mid_key = 40'h55_5555_5555;

    // End items with nothing open: empty stream, then a repeated end
    queue_record(ACT_END, '1, 8'hFF, 8'hFF);
    queue_record(ACT_END, '0, 8'h00, 8'h00);
    // Zero key; extreme moves and a duplicate
    queue_record(ACT_ADD, '0, 8'h00, 8'h00);
    queue_record(ACT_ADD, '0, 8'hFF, 8'hFF);
    queue_record(ACT_ADD, '0, 8'h00, 8'h00);
    // Key change to all ones flushes the zero group; low bits hit the pair
    queue_record(ACT_ADD, '1, 8'hA5, 8'h5A);
    // Key change again, then fill the group to capacity
    queue_record(ACT_ADD, mid_key, 8'h00, 8'hFF);
    for (int i = 1; i < GROUP_CAP; i++)
      queue_record(ACT_ADD, mid_key, BYTE_W'(i * 17), BYTE_W'(255 - i));
    // Full group: a new distinct move is dropped, a duplicate is not counted
    queue_record(ACT_ADD, mid_key, 8'h3C, 8'hC3);
    queue_record(ACT_ADD, mid_key, 8'h00, 8'hFF);
    // Flush with junk fields, then an end with nothing open
    queue_record(ACT_END, 40'hAA_AAAA_AAAA, 8'h12, 8'h34);
    queue_record(ACT_END, '1, 8'hFF, 8'hFF);

    queue_random_stream(RAND_ITEMS);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // All records accepted, all bytes seen, then a short settle
    while (record_q.size() != 0 || in_valid) @(posedge clk);
    while (line_bytes_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
